@@ design/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/cps_pkg.sv @@
// Shared types, constants and fixed-point functions for the cart-pole step block
package cps_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 21;
    localparam int FMAG_W = 21;
    localparam int TSTEP_W = 17;
    localparam int PLIM_W = 21;
    localparam int ALIM_W = 17;
    localparam int STEP_W = 6;
    localparam int DIV_BITS = 48;
    localparam int CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FMAG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIM = 3'd3;

    localparam logic [FMAG_W-1:0] FMAG_RST = 21'd655360;
    localparam logic [TSTEP_W-1:0] TSTEP_RST = 17'd1311;
    localparam logic [PLIM_W-1:0] PLIM_RST = 21'd157286;
    localparam logic [ALIM_W-1:0] ALIM_RST = 17'd13726;

    localparam logic signed [31:0] FX_ONE = 32'sd65536;
    localparam logic signed [31:0] FX_G = 32'sd642253;
    localparam logic signed [31:0] FX_PML = 32'sd3277;
    localparam logic signed [31:0] FX_INV_TM = 32'sd59578;
    localparam logic signed [31:0] FX_MP_OVER_TM = 32'sd5958;
    localparam logic signed [31:0] FX_FOUR_THIRDS = 32'sd87381;
    localparam logic signed [31:0] FX_HALF = 32'sd32768;
    localparam logic signed [31:0] FX_HALF_PI = 32'sd102944;
    localparam logic signed [31:0] K_S0 = 32'sd1560;
    localparam logic signed [31:0] K_S1 = 32'sd3277;
    localparam logic signed [31:0] K_S2 = 32'sd10923;
    localparam logic signed [31:0] K_C0 = 32'sd1170;
    localparam logic signed [31:0] K_C1 = 32'sd2185;
    localparam logic signed [31:0] K_C2 = 32'sd5461;
    localparam logic signed [31:0] K_C3 = 32'sd32768;
    localparam logic signed [31:0] BOX_POS = 32'sd52429;
    localparam logic signed [31:0] BOX_VEL = 32'sd32768;
    localparam logic signed [31:0] BOX_DEG1 = 32'sd1144;
    localparam logic signed [31:0] BOX_DEG6 = 32'sd6863;
    localparam logic signed [31:0] BOX_RATE = 32'sd57190;

    localparam logic [STEP_W-1:0] MC_CLAMP = 6'd0;
    localparam logic [STEP_W-1:0] MC_A2 = 6'd1;
    localparam logic [STEP_W-1:0] MC_S0 = 6'd2;
    localparam logic [STEP_W-1:0] MC_S1U = 6'd3;
    localparam logic [STEP_W-1:0] MC_S1 = 6'd4;
    localparam logic [STEP_W-1:0] MC_S2U = 6'd5;
    localparam logic [STEP_W-1:0] MC_S2 = 6'd6;
    localparam logic [STEP_W-1:0] MC_SIN = 6'd7;
    localparam logic [STEP_W-1:0] MC_C0 = 6'd8;
    localparam logic [STEP_W-1:0] MC_C1U = 6'd9;
    localparam logic [STEP_W-1:0] MC_C1 = 6'd10;
    localparam logic [STEP_W-1:0] MC_C2U = 6'd11;
    localparam logic [STEP_W-1:0] MC_C2 = 6'd12;
    localparam logic [STEP_W-1:0] MC_C3U = 6'd13;
    localparam logic [STEP_W-1:0] MC_COS = 6'd14;
    localparam logic [STEP_W-1:0] MC_W2 = 6'd15;
    localparam logic [STEP_W-1:0] MC_PW2 = 6'd16;
    localparam logic [STEP_W-1:0] MC_PW2S = 6'd17;
    localparam logic [STEP_W-1:0] MC_TEMP = 6'd18;
    localparam logic [STEP_W-1:0] MC_GS = 6'd19;
    localparam logic [STEP_W-1:0] MC_NUM = 6'd20;
    localparam logic [STEP_W-1:0] MC_CC = 6'd21;
    localparam logic [STEP_W-1:0] MC_DEN0 = 6'd22;
    localparam logic [STEP_W-1:0] MC_DEN = 6'd23;
    localparam logic [STEP_W-1:0] MC_DIV = 6'd24;
    localparam logic [STEP_W-1:0] MC_X0 = 6'd25;
    localparam logic [STEP_W-1:0] MC_X1 = 6'd26;
    localparam logic [STEP_W-1:0] MC_X2 = 6'd27;
    localparam logic [STEP_W-1:0] MC_XACC = 6'd28;
    localparam logic [STEP_W-1:0] MC_NX = 6'd29;
    localparam logic [STEP_W-1:0] MC_NV = 6'd30;
    localparam logic [STEP_W-1:0] MC_NTH = 6'd31;
    localparam logic [STEP_W-1:0] MC_NW = 6'd32;

    typedef struct packed {
        logic accept;
        logic exec;
        logic [STEP_W-1:0] step;
        logic div_init;
        logic div_iter;
        logic finish;
    } t_cmd;

    function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] subq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [64:0] r;
        logic signed [48:0] f;
        p = a * b;
        r = {p[63], p} + 65'sd32768;
        f = r[64:16];
        if (f[48:31] != {18{f[31]}}) return f[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return f[31:0];
    endfunction

    function automatic logic [7:0] classify(input logic signed [31:0] x,
                                            input logic signed [31:0] v,
                                            input logic signed [31:0] th,
                                            input logic signed [31:0] w);
        logic [7:0] box;
        if (x < -BOX_POS) box = 8'd0;
        else if (x < BOX_POS) box = 8'd1;
        else box = 8'd2;
        if (v >= BOX_VEL) box = box + 8'd6;
        else if (v >= -BOX_VEL) box = box + 8'd3;
        if (th >= BOX_DEG6) box = box + 8'd45;
        else if (th >= BOX_DEG1) box = box + 8'd36;
        else if (th >= 0) box = box + 8'd27;
        else if (th >= -BOX_DEG1) box = box + 8'd18;
        else if (th >= -BOX_DEG6) box = box + 8'd9;
        if (w >= BOX_RATE) box = box + 8'd108;
        else if (w >= -BOX_RATE) box = box + 8'd54;
        return box;
    endfunction

endpackage

@@ design/cps_ctrl.sv @@
// Sequencer for the cart-pole step: microstep counter, divider count, output valid
module cps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cps_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN = 2'd1;
    localparam logic [1:0] C_DIV = 2'd2;
    localparam logic [1:0] C_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic [cps_pkg::STEP_W-1:0] r_step, n_step;
    logic [cps_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_cnt = r_cnt;
        n_out_vld = r_out_vld && i_out_stall;
        o_cmd = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            C_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = C_RUN;
                    n_step = cps_pkg::MC_CLAMP;
                end
            end
            C_RUN: begin
                o_cmd.exec = 1'b1;
                if (r_step == cps_pkg::MC_DEN) begin
                    n_state = C_DIV;
                    n_step = cps_pkg::MC_DIV;
                    n_cnt = '0;
                end else if (r_step == cps_pkg::MC_NW) begin
                    n_state = C_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            C_DIV: begin
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_iter = (r_cnt != '0);
                if (r_cnt == cps_pkg::CNT_W'(cps_pkg::DIV_BITS)) begin
                    n_state = C_RUN;
                    n_step = cps_pkg::MC_X0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            C_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_vld = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step <= '0;
            r_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_cnt <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall = (r_state != C_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

@@ design/cps_dpath.sv @@
// Datapath: shared Q16.16 multiplier, restoring divider, state and result registers
module cps_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cps_pkg::t_cmd                        i_cmd,
    input  logic                                 i_push_right,
    input  logic                                 i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic [7:0]                           o_box_index,
    output logic                                 o_failed,
    output logic signed [31:0]                   o_position_out,
    output logic signed [31:0]                   o_velocity_out,
    output logic signed [31:0]                   o_angle_out,
    output logic signed [31:0]                   o_angle_rate_out
);

    logic [cps_pkg::FMAG_W-1:0] r_fmag;
    logic [cps_pkg::TSTEP_W-1:0] r_tstep;
    logic [cps_pkg::PLIM_W-1:0] r_plim;
    logic [cps_pkg::ALIM_W-1:0] r_alim;

    logic signed [31:0] r_x, r_v, r_th, r_w;
    logic signed [31:0] r_a, r_a2, r_t, r_u, r_s, r_c, r_temp, r_num, r_den;
    logic signed [31:0] r_xacc, r_nx, r_nv, r_nth, r_nw;
    logic r_push;
    logic r_neg;
    logic [31:0] r_rem;
    logic [cps_pkg::DIV_BITS-1:0] r_quo;

    logic signed [31:0] force_q, tau, thacc, op_a, op_b, prod, num_abs;
    logic [32:0] rem_sh;
    logic div_ge;
    logic fail;
    logic signed [32:0] plim_s, alim_s;

    assign force_q = r_push ? $signed({11'b0, r_fmag}) : -$signed({11'b0, r_fmag});
    assign tau = $signed({15'b0, r_tstep});

    always_comb begin
        if (!r_neg) begin
            thacc = (r_quo > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : $signed(r_quo[31:0]);
        end else begin
            thacc = (r_quo > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(r_quo[31:0]);
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.step)
            cps_pkg::MC_A2: begin op_a = r_a; op_b = r_a; end
            cps_pkg::MC_S0: begin op_a = r_a2; op_b = cps_pkg::K_S0; end
            cps_pkg::MC_S1U: begin op_a = r_a2; op_b = cps_pkg::K_S1; end
            cps_pkg::MC_S1: begin op_a = r_u; op_b = r_t; end
            cps_pkg::MC_S2U: begin op_a = r_a2; op_b = cps_pkg::K_S2; end
            cps_pkg::MC_S2: begin op_a = r_u; op_b = r_t; end
            cps_pkg::MC_SIN: begin op_a = r_a; op_b = r_t; end
            cps_pkg::MC_C0: begin op_a = r_a2; op_b = cps_pkg::K_C0; end
            cps_pkg::MC_C1U: begin op_a = r_a2; op_b = cps_pkg::K_C1; end
            cps_pkg::MC_C1: begin op_a = r_u; op_b = r_t; end
            cps_pkg::MC_C2U: begin op_a = r_a2; op_b = cps_pkg::K_C2; end
            cps_pkg::MC_C2: begin op_a = r_u; op_b = r_t; end
            cps_pkg::MC_C3U: begin op_a = r_a2; op_b = cps_pkg::K_C3; end
            cps_pkg::MC_COS: begin op_a = r_u; op_b = r_t; end
            cps_pkg::MC_W2: begin op_a = r_w; op_b = r_w; end
            cps_pkg::MC_PW2: begin op_a = cps_pkg::FX_PML; op_b = r_u; end
            cps_pkg::MC_PW2S: begin op_a = r_u; op_b = r_s; end
            cps_pkg::MC_TEMP: begin
                op_a = cps_pkg::addq(force_q, r_u);
                op_b = cps_pkg::FX_INV_TM;
            end
            cps_pkg::MC_GS: begin op_a = cps_pkg::FX_G; op_b = r_s; end
            cps_pkg::MC_NUM: begin op_a = r_c; op_b = r_temp; end
            cps_pkg::MC_CC: begin op_a = r_c; op_b = r_c; end
            cps_pkg::MC_DEN0: begin op_a = cps_pkg::FX_MP_OVER_TM; op_b = r_u; end
            cps_pkg::MC_DEN: begin op_a = cps_pkg::FX_HALF; op_b = r_u; end
            cps_pkg::MC_X0: begin op_a = cps_pkg::FX_PML; op_b = thacc; end
            cps_pkg::MC_X1: begin op_a = r_u; op_b = r_c; end
            cps_pkg::MC_X2: begin op_a = r_u; op_b = cps_pkg::FX_INV_TM; end
            cps_pkg::MC_NX: begin op_a = tau; op_b = r_v; end
            cps_pkg::MC_NV: begin op_a = tau; op_b = r_xacc; end
            cps_pkg::MC_NTH: begin op_a = tau; op_b = r_w; end
            cps_pkg::MC_NW: begin op_a = tau; op_b = thacc; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = cps_pkg::mulq(op_a, op_b);

    assign num_abs = r_num[31] ? -r_num : r_num;
    assign rem_sh = {r_rem, r_quo[cps_pkg::DIV_BITS-1]};
    assign div_ge = (rem_sh >= {1'b0, r_den});

    assign plim_s = $signed({12'b0, r_plim});
    assign alim_s = $signed({16'b0, r_alim});
    assign fail = ($signed({r_nx[31], r_nx}) < -plim_s) ||
                  ($signed({r_nx[31], r_nx}) > plim_s) ||
                  ($signed({r_nth[31], r_nth}) < -alim_s) ||
                  ($signed({r_nth[31], r_nth}) > alim_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmag <= cps_pkg::FMAG_RST;
            r_tstep <= cps_pkg::TSTEP_RST;
            r_plim <= cps_pkg::PLIM_RST;
            r_alim <= cps_pkg::ALIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cps_pkg::CFG_FMAG: r_fmag <= i_cfg_data[cps_pkg::FMAG_W-1:0];
                cps_pkg::CFG_TSTEP: r_tstep <= i_cfg_data[cps_pkg::TSTEP_W-1:0];
                cps_pkg::CFG_PLIM: r_plim <= i_cfg_data[cps_pkg::PLIM_W-1:0];
                cps_pkg::CFG_ALIM: r_alim <= i_cfg_data[cps_pkg::ALIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_v <= '0;
            r_th <= '0;
            r_w <= '0;
        end else if (i_cmd.finish) begin
            r_x <= fail ? '0 : r_nx;
            r_v <= fail ? '0 : r_nv;
            r_th <= fail ? '0 : r_nth;
            r_w <= fail ? '0 : r_nw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_failed <= fail;
            o_box_index <= fail ? 8'd0 : cps_pkg::classify(r_nx, r_nv, r_nth, r_nw);
            o_position_out <= fail ? '0 : r_nx;
            o_velocity_out <= fail ? '0 : r_nv;
            o_angle_out <= fail ? '0 : r_nth;
            o_angle_rate_out <= fail ? '0 : r_nw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_push <= i_push_right;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_num[31];
            r_rem <= '0;
            r_quo <= {num_abs, 16'b0};
        end else if (i_cmd.div_iter) begin
            r_rem <= div_ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_quo <= {r_quo[cps_pkg::DIV_BITS-2:0], div_ge};
        end
        if (i_cmd.exec) begin
            case (i_cmd.step)
                cps_pkg::MC_CLAMP: begin
                    if (r_th > cps_pkg::FX_HALF_PI) r_a <= cps_pkg::FX_HALF_PI;
                    else if (r_th < -cps_pkg::FX_HALF_PI) r_a <= -cps_pkg::FX_HALF_PI;
                    else r_a <= r_th;
                end
                cps_pkg::MC_A2: r_a2 <= prod;
                cps_pkg::MC_S0, cps_pkg::MC_S1, cps_pkg::MC_S2,
                cps_pkg::MC_C0, cps_pkg::MC_C1, cps_pkg::MC_C2:
                    r_t <= cps_pkg::subq(cps_pkg::FX_ONE, prod);
                cps_pkg::MC_S1U, cps_pkg::MC_S2U, cps_pkg::MC_C1U, cps_pkg::MC_C2U,
                cps_pkg::MC_C3U, cps_pkg::MC_W2, cps_pkg::MC_PW2, cps_pkg::MC_PW2S,
                cps_pkg::MC_GS, cps_pkg::MC_CC, cps_pkg::MC_X0, cps_pkg::MC_X1,
                cps_pkg::MC_X2:
                    r_u <= prod;
                cps_pkg::MC_SIN: r_s <= prod;
                cps_pkg::MC_COS: r_c <= cps_pkg::subq(cps_pkg::FX_ONE, prod);
                cps_pkg::MC_TEMP: r_temp <= prod;
                cps_pkg::MC_NUM: r_num <= cps_pkg::subq(r_u, prod);
                cps_pkg::MC_DEN0: r_u <= cps_pkg::subq(cps_pkg::FX_FOUR_THIRDS, prod);
                cps_pkg::MC_DEN: r_den <= (prod <= 0) ? 32'sd1 : prod;
                cps_pkg::MC_XACC: r_xacc <= cps_pkg::subq(r_temp, r_u);
                cps_pkg::MC_NX: r_nx <= cps_pkg::addq(r_x, prod);
                cps_pkg::MC_NV: r_nv <= cps_pkg::addq(r_v, prod);
                cps_pkg::MC_NTH: r_nth <= cps_pkg::addq(r_th, prod);
                cps_pkg::MC_NW: r_nw <= cps_pkg::addq(r_w, prod);
                default: ;
            endcase
        end
    end

endmodule

@@ design/cart_pole_step.sv @@
// Top level of the cart-pole step block: sequencer plus datapath
// One request at a time: the input stalls from accept until the result is registered,
// which waits on the 48-step restoring divider, on 32 microsteps on the single shared
// multiplier, and on a stalled output that still holds the previous result.
// Reset (synchronous, active low): state zero, config registers to defaults, no result pending.
module cart_pole_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_push_right,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_box_index,
    output logic                            o_failed,
    output logic signed [31:0]              o_position_out,
    output logic signed [31:0]              o_velocity_out,
    output logic signed [31:0]              o_angle_out,
    output logic signed [31:0]              o_angle_rate_out,
    input  logic                            i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cps_pkg::t_cmd cmd;

    cps_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd(cmd)
    );

    cps_dpath u_dpath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_push_right(i_push_right),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_box_index(o_box_index),
        .o_failed(o_failed),
        .o_position_out(o_position_out),
        .o_velocity_out(o_velocity_out),
        .o_angle_out(o_angle_out),
        .o_angle_rate_out(o_angle_rate_out)
    );

endmodule

@@ design/cps_checker.sv @@
// Port-level checker for the cart-pole step block, bound to the top level
`include "assert_macros.svh"

module cps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        o_box_index,
    input logic              o_failed,
    input logic signed [31:0] o_position_out,
    input logic signed [31:0] o_velocity_out,
    input logic signed [31:0] o_angle_out,
    input logic signed [31:0] o_angle_rate_out
);

    `AST_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall)
    `AST_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `AST_IMPLY(a_box_range, o_out_valid, o_box_index <= 8'd161)
    `AST_IMPLY(a_fail_zero, o_out_valid && o_failed, o_box_index == 8'd0 && o_position_out == 0 && o_velocity_out == 0 && o_angle_out == 0 && o_angle_rate_out == 0)

endmodule

bind cart_pole_step cps_checker u_cps_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_box_index(o_box_index),
    .o_failed(o_failed),
    .o_position_out(o_position_out),
    .o_velocity_out(o_velocity_out),
    .o_angle_out(o_angle_out),
    .o_angle_rate_out(o_angle_rate_out)
);
